FILE: src/sliding_window_average_macros.svh
// Assertion macros shared by the sliding window average design.
// The module that uses them must have signals named clock and reset.
`ifndef SLIDING_WINDOW_AVERAGE_MACROS_SVH
`define SLIDING_WINDOW_AVERAGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sliding window average check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sliding window average check failed");

`endif

FILE: src/swa_pkg.sv
// Package for the sliding window average: field widths, parameter defaults
// and the divider status type. No dependencies.
package swa_pkg;

   localparam int SAMPLE_W = 32;
   localparam int OUT_W = 39;
   localparam int WIN_W = 7;

   localparam int WINDOW_MAX_DEF = 64;
   localparam int SAMPLE_BITS_DEF = 32;

   typedef struct packed {
      logic busy;
      logic done;
   } swa_div_status_type;

endpackage

FILE: src/swa_req_if.sv
// Request channel interface of the sliding window average.
// Depends on swa_pkg for the sample width.
interface swa_req_if;
   logic valid;
   logic ready;
   logic [swa_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

FILE: src/swa_rsp_if.sv
// Response channel interface of the sliding window average.
// Depends on swa_pkg for the result width.
interface swa_rsp_if;
   logic valid;
   logic ready;
   logic window_full;
   logic signed [swa_pkg::OUT_W-1:0] average_hundredths;

   modport source (output valid, output window_full, output average_hundredths,
                   input ready);
   modport sink (input valid, input window_full, input average_hundredths,
                 output ready);
endinterface

FILE: src/swa_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on swa_pkg and the assertion macro header.
`include "sliding_window_average_macros.svh"

module swa_divider #(
   parameter int DIVIDEND_W = 47,
   parameter int DIVISOR_W = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [DIVIDEND_W-1:0]          dividend,
   input  logic [DIVISOR_W-1:0]           divisor,
   output logic [DIVIDEND_W-1:0]          quotient,
   output swa_pkg::swa_div_status_type    status
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] acc_ff, acc_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   always_comb begin
      shifted = {rem_ff, acc_ff[DIVIDEND_W-1]};
      diff = shifted - {1'b0, divisor_ff};
      ge = shifted >= {1'b0, divisor_ff};

      acc_in = acc_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         acc_in = dividend;
         rem_in = '0;
         divisor_in = divisor;
         cnt_in = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[DIVIDEND_W-2:0], ge};
         rem_in = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `SWA_ASSERT_NEXT(a_start_sets_busy, start, busy_ff)
   `SWA_ASSERT_SAME(a_rem_below_divisor, busy_ff, rem_ff < divisor_ff)
   `SWA_ASSERT_SAME(a_done_not_busy, done_ff, !busy_ff)

endmodule

FILE: src/sliding_window_average.sv
// Channel    | Dir | Payload
// req_ch     | in  | sample (32 bits, signed)
// rsp_ch     | out | window_full, average_hundredths (39 bits, signed)
// csr_wr_*   | in  | window_size (7 bits), write only
// A request passes S_SUB, S_ADD, S_MAG, S_SCL1, S_SCL2, S_DIV and S_DONE in that order;
// the bit-serial divider takes DIV_W = SAMPLE_BITS + log2(WINDOW_MAX) + 9 bits, 47 at the defaults.
// A request that leaves the window not full goes from S_ADD straight to S_DONE.
// Reset is synchronous; the window size returns to 1 and the window restarts.
// The next request is taken while a finished response still waits on rsp_ch.
// Depends on swa_pkg, swa_req_if, swa_rsp_if, swa_divider and the macro header.
`include "sliding_window_average_macros.svh"

module sliding_window_average #(
   parameter int WINDOW_MAX = swa_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [swa_pkg::WIN_W-1:0]   csr_wr_data,
   swa_req_if.sink                     req_ch,
   swa_rsp_if.source                   rsp_ch
);

   localparam int WIN_W = swa_pkg::WIN_W;
   localparam int OUT_W = swa_pkg::OUT_W;
   localparam int POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
   localparam int DIV_W = SUM_W + 8;
   localparam int DVS_W = WIN_W + 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUB  = 3'd1;
   localparam logic [2:0] S_ADD  = 3'd2;
   localparam logic [2:0] S_MAG  = 3'd3;
   localparam logic [2:0] S_SCL1 = 3'd4;
   localparam logic [2:0] S_SCL2 = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [WIN_W-1:0]          n_ff, n_in;
   logic [WIN_W-1:0]          fill_ff, fill_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]    sample_ff, sample_in;
   logic [SUM_W-1:0]          mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [DIV_W-1:0]          acc_ff, acc_in;
   logic                      full_ff, full_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_full_ff, rsp_full_in;
   logic [OUT_W-1:0]          rsp_avg_ff, rsp_avg_in;

   logic [SAMPLE_BITS-1:0]    ring_mem [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0]    ring_rd_ff;

   logic [WIN_W-1:0]          eff_window;
   logic                      req_fire;
   logic                      rsp_load;
   logic [SUM_W-1:0]          rd_ext;
   logic [SUM_W-1:0]          sample_ext;
   logic [POS_W:0]            pos_inc;
   logic [OUT_W-1:0]          q_out;
   logic                      div_start;
   logic [DIV_W-1:0]          div_q;
   swa_pkg::swa_div_status_type div_st;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign div_start = (state_ff == S_SCL2);

   assign rd_ext = {{(SUM_W-SAMPLE_BITS){ring_rd_ff[SAMPLE_BITS-1]}}, ring_rd_ff};
   assign sample_ext = {{(SUM_W-SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}}, sample_ff};
   assign pos_inc = {1'b0, pos_ff} + 1'b1;
   assign q_out = OUT_W'(div_q);

   always_comb begin
      if (csr_wr_data == '0) begin
         eff_window = WIN_W'(1);
      end else if (int'(csr_wr_data) > WINDOW_MAX) begin
         eff_window = WIN_W'(WINDOW_MAX);
      end else begin
         eff_window = csr_wr_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      fill_in = fill_ff;
      pos_in = pos_ff;
      sum_in = sum_ff;
      sample_in = sample_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      full_in = full_ff;
      rsp_full_in = rsp_full_ff;
      rsp_avg_in = rsp_avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sample_in = req_ch.sample[SAMPLE_BITS-1:0];
               state_in = S_SUB;
            end
         end
         S_SUB: begin
            if (fill_ff >= n_ff) begin
               sum_in = sum_ff - rd_ext;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
            if (int'(pos_inc) >= int'(n_ff)) begin
               pos_in = '0;
            end else begin
               pos_in = pos_inc[POS_W-1:0];
            end
            state_in = S_ADD;
         end
         S_ADD: begin
            sum_in = sum_ff + sample_ext;
            full_in = (fill_ff >= n_ff);
            state_in = (fill_ff >= n_ff) ? S_MAG : S_DONE;
         end
         S_MAG: begin
            neg_in = sum_ff[SUM_W-1];
            mag_in = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
            state_in = S_SCL1;
         end
         S_SCL1: begin
            // The scale factor 200 is 128 + 64 + 8.
            acc_in = (DIV_W'(mag_ff) << 7) + (DIV_W'(mag_ff) << 6);
            state_in = S_SCL2;
         end
         S_SCL2: begin
            acc_in = acc_ff + (DIV_W'(mag_ff) << 3) + DIV_W'(n_ff);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_st.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_full_in = full_ff;
               if (full_ff) begin
                  rsp_avg_in = neg_ff ? -q_out : q_out;
               end else begin
                  rsp_avg_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         n_in = eff_window;
         sum_in = '0;
         pos_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      full_ff <= full_in;
      rsp_full_ff <= rsp_full_in;
      rsp_avg_ff <= rsp_avg_in;
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff <= WIN_W'(1);
         fill_ff <= '0;
         pos_ff <= '0;
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         fill_ff <= fill_in;
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ring_mem[pos_ff] <= req_ch.sample[SAMPLE_BITS-1:0];
         ring_rd_ff <= ring_mem[pos_ff];
      end
   end

   swa_divider #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (DVS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_in),
      .divisor  ({n_ff, 1'b0}),
      .quotient (div_q),
      .status   (div_st)
   );

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.window_full = rsp_full_ff;
   assign rsp_ch.average_hundredths = rsp_avg_ff;

   `SWA_ASSERT_SAME(a_fill_in_window, 1'b1, fill_ff <= n_ff)
   `SWA_ASSERT_SAME(a_pos_in_window, 1'b1, int'(pos_ff) < int'(n_ff))
   `SWA_ASSERT_SAME(a_full_before_scale, state_ff == S_MAG, fill_ff == n_ff)
   `SWA_ASSERT_NEXT(a_div_to_done, (state_ff == S_DIV) && div_st.done, state_ff == S_DONE)

endmodule
